/* rtl/lpc_pkg.sv */
// ============================================================================
// lpc_pkg
// Shared types and constants of the LFU picture cache directory.
// ============================================================================
package lpc_pkg;

    localparam int ENTRIES     = 512;
    localparam int COUNT_BITS  = 24;
    localparam int IDX_BITS    = $clog2(ENTRIES);
    localparam int MODEL_BITS  = 20;
    localparam int PIC_BITS    = 10;
    localparam int SLOT_BITS   = 9;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_PURGE   = 1'b1;

    typedef struct packed {
        logic [MODEL_BITS-1:0] tag_model;
        logic [PIC_BITS-1:0]   tag_picture;
        logic                  tag_quality;
        logic [COUNT_BITS-1:0] use_count;
        logic                  data_valid;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        entry_t              wr_data;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                 hit;
        logic                 loaded;
        logic                 found;
        logic [SLOT_BITS-1:0] slot_used;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PURGE_RD,
        ST_PURGE_WAIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* rtl/lpc_ram.sv */
// ============================================================================
// lpc_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lpc_ctrl.sv */
// ============================================================================
// lpc_ctrl
// Sequencer of the cache directory: clearing pass, entry scan with LFU victim
// search, purge read-modify-write and the final write-back of one entry.
// ============================================================================
module lpc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [lpc_pkg::MODEL_BITS-1:0] model_id,
    input  logic [lpc_pkg::PIC_BITS-1:0]  picture,
    input  logic                          high_quality,
    input  logic                          load_ok,
    input  logic [lpc_pkg::SLOT_BITS-1:0] slot,
    output lpc_pkg::mem_req_t             mem_req,
    input  lpc_pkg::entry_t               rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lpc_pkg::res_t                 res
);

    localparam logic [lpc_pkg::IDX_BITS-1:0] LAST_IDX =
        lpc_pkg::IDX_BITS'(lpc_pkg::ENTRIES - 1);

    lpc_pkg::state_t state_reg;
    lpc_pkg::state_t state_next;

    logic [lpc_pkg::IDX_BITS-1:0]   clr_idx_reg;
    logic [lpc_pkg::IDX_BITS-1:0]   scan_addr_reg;
    logic                           issue_done_reg;
    logic                           chk_valid_reg;
    logic [lpc_pkg::IDX_BITS-1:0]   chk_idx_reg;

    logic                           mode_reg;
    logic [lpc_pkg::MODEL_BITS-1:0] model_reg;
    logic [lpc_pkg::PIC_BITS-1:0]   picture_reg;
    logic                           quality_reg;
    logic                           load_ok_reg;
    logic [lpc_pkg::IDX_BITS-1:0]   purge_idx_reg;
    logic                           purge_ok_reg;

    logic                           matched_reg;
    lpc_pkg::entry_t                hold_reg;
    logic [lpc_pkg::IDX_BITS-1:0]   used_idx_reg;
    lpc_pkg::entry_t                victim_reg;
    logic [lpc_pkg::IDX_BITS-1:0]   victim_idx_reg;
    logic [lpc_pkg::COUNT_BITS-1:0] min_count_reg;

    logic                           key_match;
    logic                           slot_in_range;
    logic                           fin_wr;
    logic [lpc_pkg::IDX_BITS-1:0]   fin_addr;
    lpc_pkg::entry_t                fin_word;

    assign key_match = (rd_data.tag_model == model_reg) &&
                       (rd_data.tag_picture == picture_reg) &&
                       (rd_data.tag_quality == quality_reg);

    assign slot_in_range = (32'(slot) < lpc_pkg::ENTRIES);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpc_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = lpc_pkg::ST_IDLE;
                end
            end
            lpc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == lpc_pkg::MODE_PURGE)
                    begin
                        state_next = slot_in_range ? lpc_pkg::ST_PURGE_RD
                                                   : lpc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = lpc_pkg::ST_SCAN;
                    end
                end
            end
            lpc_pkg::ST_PURGE_RD:
            begin
                state_next = lpc_pkg::ST_PURGE_WAIT;
            end
            lpc_pkg::ST_PURGE_WAIT:
            begin
                state_next = lpc_pkg::ST_FINISH;
            end
            lpc_pkg::ST_SCAN:
            begin
                if (chk_valid_reg && (key_match || chk_idx_reg == LAST_IDX))
                begin
                    state_next = lpc_pkg::ST_FINISH;
                end
            end
            lpc_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = lpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Result and write-back word of the item in hand.
    always_comb
    begin
        res      = '0;
        fin_wr   = 1'b0;
        fin_addr = used_idx_reg;
        fin_word = hold_reg;
        if (mode_reg == lpc_pkg::MODE_PURGE)
        begin
            fin_wr              = purge_ok_reg;
            fin_addr            = purge_idx_reg;
            fin_word.data_valid = 1'b0;
        end
        else if (matched_reg)
        begin
            fin_wr        = 1'b1;
            res.slot_used = lpc_pkg::SLOT_BITS'(used_idx_reg);
            if (hold_reg.data_valid)
            begin
                res.hit   = 1'b1;
                res.found = 1'b1;
                if (hold_reg.use_count != '1)
                begin
                    fin_word.use_count = hold_reg.use_count + 1'b1;
                end
            end
            else
            begin
                res.loaded          = 1'b1;
                res.found           = load_ok_reg;
                fin_word.data_valid = load_ok_reg;
            end
        end
        else
        begin
            fin_wr        = 1'b1;
            fin_addr      = victim_idx_reg;
            res.slot_used = lpc_pkg::SLOT_BITS'(victim_idx_reg);
            res.loaded    = 1'b1;
            res.found     = load_ok_reg;
            if (load_ok_reg)
            begin
                fin_word.tag_model   = model_reg;
                fin_word.tag_picture = picture_reg;
                fin_word.tag_quality = quality_reg;
                fin_word.use_count   = lpc_pkg::COUNT_BITS'(1);
                fin_word.data_valid  = 1'b1;
            end
            else
            begin
                fin_word            = victim_reg;
                fin_word.data_valid = 1'b0;
            end
        end
    end

    // Handshake and memory port outputs.
    always_comb
    begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_req         = '0;
        mem_req.wr_addr = fin_addr;
        mem_req.wr_data = fin_word;
        mem_req.rd_addr = scan_addr_reg;
        case (state_reg)
            lpc_pkg::ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_idx_reg;
                mem_req.wr_data = '0;
            end
            lpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lpc_pkg::ST_PURGE_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = purge_idx_reg;
            end
            lpc_pkg::ST_SCAN:
            begin
                mem_req.rd_en = !issue_done_reg;
            end
            lpc_pkg::ST_FINISH:
            begin
                res_valid     = 1'b1;
                mem_req.wr_en = fin_wr && res_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpc_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= (state_reg == lpc_pkg::ST_SCAN) && !issue_done_reg;
            if (state_reg == lpc_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= scan_addr_reg;
        if (state_reg == lpc_pkg::ST_IDLE && in_valid)
        begin
            mode_reg       <= mode;
            model_reg      <= model_id;
            picture_reg    <= picture;
            quality_reg    <= high_quality;
            load_ok_reg    <= load_ok;
            purge_idx_reg  <= lpc_pkg::IDX_BITS'(slot);
            purge_ok_reg   <= slot_in_range;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            matched_reg    <= 1'b0;
        end
        if (state_reg == lpc_pkg::ST_PURGE_WAIT)
        begin
            hold_reg <= rd_data;
        end
        if (state_reg == lpc_pkg::ST_SCAN)
        begin
            if (!issue_done_reg)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                if (scan_addr_reg == LAST_IDX)
                begin
                    issue_done_reg <= 1'b1;
                end
            end
            if (chk_valid_reg)
            begin
                if (chk_idx_reg == '0 || rd_data.use_count < min_count_reg)
                begin
                    min_count_reg  <= rd_data.use_count;
                    victim_idx_reg <= chk_idx_reg;
                    victim_reg     <= rd_data;
                end
                if (key_match)
                begin
                    matched_reg  <= 1'b1;
                    hold_reg     <= rd_data;
                    used_idx_reg <= chk_idx_reg;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.hit |-> res.found && !res.loaded)
        else $error("hit result without found or with load");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpc_pkg::ST_SCAN |-> !mem_req.wr_en)
        else $error("memory write during entry scan");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == lpc_pkg::ST_CLEAR) && state_reg == lpc_pkg::ST_IDLE
        |-> $past(clr_idx_reg) == LAST_IDX)
        else $error("clearing pass left early");

    a_one_write_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en && state_reg == lpc_pkg::ST_FINISH
        |=> state_reg == lpc_pkg::ST_IDLE)
        else $error("write-back repeated for one item");
`endif

endmodule

/* rtl/lfu_picture_cache_policy.sv */
// A picture request is accepted in idle, then the scan reads the entries in
// order up to the first key match (all ENTRIES on a miss), and the finish
// state writes the used entry back. A purge notice for a slot in range reads
// that entry and writes it back invalid. Throughput: one item at a time; a new
// item is taken only in idle. Reset: asynchronous; a clearing pass zeroes every
// RAM entry while no item is taken.
// ============================================================================
// lfu_picture_cache_policy
// Fully associative picture cache directory with least-frequently-used
// replacement; entry RAM, sequencer and an output register.
// ============================================================================
module lfu_picture_cache_policy (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [lpc_pkg::MODEL_BITS-1:0] model_id,
    input  logic [lpc_pkg::PIC_BITS-1:0]   picture,
    input  logic                           high_quality,
    input  logic                           load_ok,
    input  logic [lpc_pkg::SLOT_BITS-1:0]  slot,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic                           loaded,
    output logic                           found,
    output logic [lpc_pkg::SLOT_BITS-1:0]  slot_used
);

    lpc_pkg::mem_req_t mem_req;
    lpc_pkg::entry_t   rd_data;
    logic [lpc_pkg::ENTRY_BITS-1:0] rd_bits;
    logic              res_valid;
    logic              res_ready;
    lpc_pkg::res_t     res;
    logic              out_valid_reg;
    lpc_pkg::res_t     out_reg;

    lpc_ram #(
        .WIDTH (lpc_pkg::ENTRY_BITS),
        .DEPTH (lpc_pkg::ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data = lpc_pkg::entry_t'(rd_bits);

    lpc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .model_id     (model_id),
        .picture      (picture),
        .high_quality (high_quality),
        .load_ok      (load_ok),
        .slot         (slot),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_reg.hit;
    assign loaded    = out_reg.loaded;
    assign found     = out_reg.found;
    assign slot_used = out_reg.slot_used;

endmodule
